[sv/mtf_pkg.sv]
`timescale 1ns / 1ps
// Package with the word types, opcodes and status codes of the move-to-front list engine.
package mtf_pkg;

  localparam logic [3:0] OP_INS_FRONT  = 4'd0;
  localparam logic [3:0] OP_INS_BACK   = 4'd1;
  localparam logic [3:0] OP_INS_AFTER  = 4'd2;
  localparam logic [3:0] OP_INS_BEFORE = 4'd3;
  localparam logic [3:0] OP_DEL_FRONT  = 4'd4;
  localparam logic [3:0] OP_DEL_BACK   = 4'd5;
  localparam logic [3:0] OP_DEL_KEY    = 4'd6;
  localparam logic [3:0] OP_READ_FWD   = 4'd7;
  localparam logic [3:0] OP_READ_BACK  = 4'd8;
  localparam logic [3:0] OP_REVERSE    = 4'd9;
  localparam logic [3:0] OP_MOVE_FRONT = 4'd10;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Per-cell control: what every cell does at a clock edge.
  localparam logic [2:0] CC_HOLD  = 3'd0;
  localparam logic [2:0] CC_SHR   = 3'd1; // take the left neighbour (open a gap)
  localparam logic [2:0] CC_SHL   = 3'd2; // take the right neighbour (close a gap)
  localparam logic [2:0] CC_LOAD  = 3'd3; // take the new value
  localparam logic [2:0] CC_ROTL  = 3'd4; // circular shift towards the front

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
    logic [4:0]         occupancy;
  } out_word_t;

endpackage

[sv/mtf_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the list: holds an entry and shifts to either neighbour.
module mtf_cell
  import mtf_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         ctrl,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  input  logic signed [31:0] load_data,
  output logic signed [31:0] data_q
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // Select the next content of the cell.
  always_comb begin
    case (ctrl)
      CC_SHR:  data_nxt = left_data;
      CC_SHL:  data_nxt = right_data;
      CC_ROTL: data_nxt = right_data;
      CC_LOAD: data_nxt = load_data;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[sv/move_to_front_list_engine_top.sv]
`timescale 1ns / 1ps
// Move-to-front list engine: a row of cells steered by a sequencer.
// Front and back inserts, front and back deletes and refusals answer straight from the idle state;
// key operations first search the row for the key, and a reverse walks the list before it answers.
// Reads return one word per cycle while out_ready is high; a new word is taken only in the cycle
// after the last result leaves, so an item is finished before the next one is taken.
// Synchronous active-low reset empties the list; cell contents are not cleared.
module move_to_front_list_engine_top
  import mtf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1; // compare one entry per cycle with the key
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_REV  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // entry count
  logic [CW-1:0] step_r, step_nxt;    // walk counter
  in_word_t      cmd_r, cmd_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     od_r, od_nxt;

  logic [2:0]          ctrl [DEPTH];
  logic signed [31:0]  q    [DEPTH];
  logic signed [31:0]  ld;
  // Boundary inputs and cell range for shifts.
  logic [CW-1:0] lo, hi;
  logic [2:0]    mode;
  logic          empty, full;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] l_in, r_in;
      assign l_in = (g == 0) ? ld : q[(g == 0) ? 0 : g-1];
      assign r_in = (g == DEPTH-1) ? q[0] : q[(g == DEPTH-1) ? 0 : g+1];
      mtf_cell u_cell (
        .clk(clk), .ctrl(ctrl[g]), .left_data(l_in), .right_data(r_in),
        .load_data(ld), .data_q(q[g])
      );
    end
  endgenerate

  // Cell controls: mode applies to cells in [lo, hi]; the cell at lo loads for a right shift.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i] = CC_HOLD;
      if (CW'(i) >= lo && CW'(i) <= hi) begin
        case (mode)
          CC_SHR:  ctrl[i] = (CW'(i) == lo) ? CC_LOAD : CC_SHR;
          CC_SHL:  ctrl[i] = CC_SHL;
          default: ctrl[i] = CC_HOLD;
        endcase
      end
    end
  end

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r >= CW'(DEPTH));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    cmd_nxt   = cmd_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    mode      = CC_HOLD;
    lo        = '0;
    hi        = '0;
    ld        = cmd_r.value;
    in_ready  = (state_r == S_IDLE) && !ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt      = in_data;
          od_nxt       = '0;
          od_nxt.last  = 1'b1;
          ov_nxt       = 1'b1;
          case (in_data.opcode) inside
            OP_INS_FRONT, OP_INS_BACK: begin
              if (full) od_nxt.status = ST_FULL;
              else begin
                ld   = in_data.value;
                mode = CC_SHR;
                lo   = (in_data.opcode == OP_INS_FRONT) ? '0 : cnt_r;
                hi   = cnt_r;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_INS_AFTER, OP_INS_BEFORE, OP_DEL_KEY, OP_MOVE_FRONT: begin
              if (empty) od_nxt.status = ST_EMPTY;
              else if (full && (in_data.opcode == OP_INS_AFTER ||
                                in_data.opcode == OP_INS_BEFORE))
                od_nxt.status = ST_FULL;
              else begin
                ov_nxt    = 1'b0;
                state_nxt = S_SRCH;
                step_nxt  = '0;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (empty) od_nxt.status = ST_EMPTY;
              else if (in_data.opcode == OP_DEL_FRONT) begin
                od_nxt.data = q[0];
                mode = CC_SHL;
                lo   = '0;
                hi   = cnt_r - 1'b1;
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                od_nxt.data = q[IW'(cnt_r - 1'b1)];
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_READ_FWD, OP_READ_BACK: begin
              if (empty) od_nxt.status = ST_EMPTY;
              else begin
                ov_nxt    = 1'b0;
                state_nxt = S_READ;
                step_nxt  = '0;
              end
            end
            OP_REVERSE: begin
              ov_nxt    = 1'b0;
              state_nxt = S_REV;
              step_nxt  = '0;
            end
            default: ;
          endcase
          od_nxt.occupancy = 5'(cnt_nxt);
        end
      end
      // Walk the row front to back; act on the first match in the same cycle.
      S_SRCH: begin
        if (q[IW'(step_r)] == cmd_r.key) begin
          ov_nxt      = 1'b1;
          od_nxt      = '0;
          od_nxt.last = 1'b1;
          state_nxt   = S_IDLE;
          case (cmd_r.opcode)
            OP_INS_AFTER: begin
              mode = CC_SHR; lo = step_r + 1'b1; hi = cnt_r;
              cnt_nxt = cnt_r + 1'b1;
            end
            OP_INS_BEFORE: begin
              mode = CC_SHR; lo = step_r; hi = cnt_r;
              cnt_nxt = cnt_r + 1'b1;
            end
            OP_DEL_KEY: begin
              od_nxt.data = q[IW'(step_r)];
              mode = CC_SHL; lo = step_r; hi = cnt_r - 1'b1;
              cnt_nxt = cnt_r - 1'b1;
            end
            OP_MOVE_FRONT: begin
              ld   = q[IW'(step_r)];
              mode = CC_SHR; lo = '0; hi = step_r;
            end
            default: ;
          endcase
          od_nxt.occupancy = 5'(cnt_nxt);
        end else if (step_r + 1'b1 == cnt_r) begin
          ov_nxt           = 1'b1;
          od_nxt           = '0;
          od_nxt.last      = 1'b1;
          od_nxt.status    = ST_NOT_FOUND;
          od_nxt.occupancy = 5'(cnt_r);
          state_nxt        = S_IDLE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_READ: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          od_nxt.data = (cmd_r.opcode == OP_READ_FWD) ? q[IW'(step_r)]
                                                       : q[IW'(cnt_r - 1'b1 - step_r)];
          od_nxt.occupancy = 5'(cnt_r);
          od_nxt.last = (step_r + 1'b1 == cnt_r);
          step_nxt = step_r + 1'b1;
          if (step_r + 1'b1 == cnt_r) state_nxt = S_IDLE;
        end
      end
      // Reverse by repeatedly taking the back entry to slot step.
      S_REV: begin
        if (step_r + 1'b1 >= cnt_r) begin
          ov_nxt           = 1'b1;
          od_nxt           = '0;
          od_nxt.last      = 1'b1;
          od_nxt.occupancy = 5'(cnt_r);
          state_nxt        = S_IDLE;
        end else begin
          ld   = q[IW'(cnt_r - 1'b1)];
          mode = CC_SHR; lo = step_r; hi = cnt_r - 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
    end
    cmd_r <= cmd_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule
